@@ hw/rtl/cst_pkg.sv @@
// Shared types and constants for the character substitution core.
// Used by cst_front, cst_queue, cst_back and the top level.
package cst_pkg;

    localparam int CAPACITY     = 128;
    localparam int PATTERN_MAX  = 32;
    localparam int RESULT_LIMIT = 32;
    localparam int QUEUE_DEPTH  = 2;

    localparam int CHAR_W   = 8;
    localparam int INDEX_W  = $clog2(PATTERN_MAX);
    localparam int LEN_W    = 6;
    localparam int COUNT_W  = 8;
    localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int S_DATA_W = 24;

    localparam int LEN_LIMIT_I = (PATTERN_MAX < RESULT_LIMIT) ? PATTERN_MAX : RESULT_LIMIT;
    localparam logic [LEN_W-1:0]   LEN_LIMIT = LEN_W'(LEN_LIMIT_I);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic REG_TARGET_CHAR    = 1'b0;
    localparam logic REG_PATTERN_LENGTH = 1'b1;

    localparam logic KIND_TEXT    = 1'b0;
    localparam logic KIND_PATTERN = 1'b1;

    typedef enum logic [1:0] {
        CMD_PASS,
        CMD_WRITE,
        CMD_EXPAND
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t             op;
        logic [CHAR_W-1:0]   data;
        logic [INDEX_W-1:0]  idx;
        logic [LEN_W-1:0]    len;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic {
        BK_IDLE,
        BK_STREAM
    } back_state_t;

endpackage

@@ hw/rtl/char_to_sequence_substitution_core.sv @@
// Character substitution core, top level.
// Depends on cst_pkg, cst_front, cst_queue and cst_back.
//
// Streams text bytes and replaces every byte equal to target_char with the
// first pattern_length bytes (at most 32) of a pattern store, which is loaded
// beforehand by items with s_tuser = 1. A match whose expansion would bring the
// working text length (bytes emitted plus bytes not yet seen) to 128 or more is
// dropped, as is a match with an empty pattern; inserted bytes are not rescanned.
// Plain text streams at one item per cycle while m_tready is high and no
// expansion is under way; a match that expands is played out by the back-end
// sequencer, which reads the single-port pattern memory one byte a cycle while
// the output is free; dropped matches never enter the queue. A two-entry
// command queue sits between the classifier and the sequencer. A pass-through
// result is registered in the queue and then in the output register; the first
// byte of an expansion also passes through the pattern read register.
module char_to_sequence_substitution_core
    import cst_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CHAR_W-1:0]   cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // char_value[7:0], pattern_index[12:8], text_length[20:13]
    input  logic [0:0]          s_tuser,  // kind[0]
    input  logic                s_tlast,  // text_end
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [CHAR_W-1:0]   m_tdata,  // out_char[7:0]
    output logic                m_tlast   // run_last
);

    logic          push;
    cmd_t          push_cmd;
    logic          pop;
    cmd_t          head;
    queue_status_t q_status;

    cst_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .q_status  (q_status),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    cst_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    cst_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ hw/rtl/cst_front.sv @@
// Front end: configuration registers, text counters and item classification.
// Depends on cst_pkg; feeds commands into cst_queue.
module cst_front
    import cst_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CHAR_W-1:0]   cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [0:0]          s_tuser,
    input  logic                s_tlast,
    input  queue_status_t       q_status,
    output logic                push,
    output cmd_t                push_cmd
);

    localparam logic [9:0] CAP_W = 10'(CAPACITY);

    logic [CHAR_W-1:0]  target_reg;
    logic [LEN_W-1:0]   plen_reg;
    logic [COUNT_W-1:0] emitted_reg, emitted_next;
    logic [COUNT_W-1:0] consumed_reg, consumed_next;

    logic               accept;
    logic [CHAR_W-1:0]  ch;
    logic [INDEX_W-1:0] idx;
    logic [COUNT_W-1:0] tlen;
    logic               is_text;
    logic               match;
    logic [LEN_W-1:0]   eff_len;
    logic [8:0]         cons_plus;
    logic [8:0]         rest_diff;
    logic [COUNT_W-1:0] rest;
    logic [9:0]         total;
    logic               fits;

    function automatic logic [COUNT_W-1:0] sat8(input logic [9:0] v);
        return (v > 10'(COUNT_MAX)) ? COUNT_MAX : v[COUNT_W-1:0];
    endfunction

    assign ch      = s_tdata[7:0];
    assign idx     = s_tdata[12:8];
    assign tlen    = s_tdata[20:13];
    assign is_text = (s_tuser[0] == KIND_TEXT);

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    assign match     = (ch == target_reg);
    assign eff_len   = (plen_reg > LEN_LIMIT) ? LEN_LIMIT : plen_reg;
    assign cons_plus = {1'b0, consumed_reg} + 9'd1;
    assign rest_diff = {1'b0, tlen} - cons_plus;
    assign rest      = ({1'b0, tlen} > cons_plus) ? rest_diff[COUNT_W-1:0] : '0;
    assign total     = {2'b00, emitted_reg} + {2'b00, rest} + {4'b0000, eff_len};
    assign fits      = (eff_len != '0) && (total < CAP_W);

    always_comb begin
        push_cmd.op   = CMD_PASS;
        push_cmd.data = ch;
        push_cmd.idx  = idx;
        push_cmd.len  = eff_len;
        push          = 1'b0;
        emitted_next  = emitted_reg;
        consumed_next = consumed_reg;
        if (!is_text) begin
            push_cmd.op = CMD_WRITE;
            push        = accept;
        end else if (!match) begin
            push         = accept;
            emitted_next = sat8({2'b00, emitted_reg} + 10'd1);
        end else begin
            push_cmd.op = CMD_EXPAND;
            push        = accept && fits;
            if (fits) begin
                emitted_next = sat8({2'b00, emitted_reg} + {4'b0000, eff_len});
            end
        end
        if (is_text) begin
            consumed_next = sat8({2'b00, consumed_reg} + 10'd1);
            if (s_tlast) begin
                emitted_next  = '0;
                consumed_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg   <= '0;
            plen_reg     <= '0;
            emitted_reg  <= '0;
            consumed_reg <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_TARGET_CHAR:    target_reg <= cfg_wdata;
                    REG_PATTERN_LENGTH: plen_reg   <= cfg_wdata[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (accept && is_text) begin
                emitted_reg  <= emitted_next;
                consumed_reg <= consumed_next;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> s_tvalid && s_tready)
        else $error("command pushed without an accepted item");

endmodule

@@ hw/rtl/cst_queue.sv @@
// Short command queue between front and back ends.
// Depends on cst_pkg.
module cst_queue
    import cst_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  cmd_t          push_cmd,
    input  logic          pop,
    output cmd_t          head,
    output queue_status_t status
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && status.full))
        else $error("push into full queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && status.empty))
        else $error("pop from empty queue");

endmodule

@@ hw/rtl/cst_back.sv @@
// Back end: pattern memory, expansion sequencer and output register.
// Depends on cst_pkg; drains commands from cst_queue.
module cst_back
    import cst_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              head,
    input  queue_status_t     q_status,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CHAR_W-1:0] m_tdata,
    output logic              m_tlast
);

    back_state_t        state_reg, state_next;
    logic [INDEX_W-1:0] k_reg, k_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [CHAR_W-1:0]  out_data_reg;
    logic               out_last_reg;
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  rd_data_reg;
    logic [CHAR_W-1:0]  pat_mem [PATTERN_MAX];

    logic               out_free;
    logic               stream_last;
    logic               rd_en;
    logic [INDEX_W-1:0] rd_addr;
    logic               wr_en;
    logic               load;
    logic [CHAR_W-1:0]  load_data;
    logic               load_last;

    assign out_free    = !out_valid_reg || m_tready;
    assign stream_last = (({1'b0, k_reg} + 1'b1) == len_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (!q_status.empty && head.op == CMD_EXPAND) begin
                    state_next = BK_STREAM;
                end
            end
            BK_STREAM: begin
                if (out_free && stream_last) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        pop       = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = k_reg;
        wr_en     = 1'b0;
        load      = 1'b0;
        load_data = rd_data_reg;
        load_last = 1'b0;
        k_next    = k_reg;
        len_next  = len_reg;
        case (state_reg)
            BK_IDLE: begin
                if (!q_status.empty) begin
                    case (head.op)
                        CMD_PASS: begin
                            if (out_free) begin
                                pop       = 1'b1;
                                load      = 1'b1;
                                load_data = head.data;
                                load_last = 1'b1;
                            end
                        end
                        CMD_WRITE: begin
                            pop   = 1'b1;
                            wr_en = 1'b1;
                        end
                        CMD_EXPAND: begin
                            pop      = 1'b1;
                            rd_en    = 1'b1;
                            rd_addr  = '0;
                            k_next   = '0;
                            len_next = head.len;
                        end
                        default: pop = 1'b1;
                    endcase
                end
            end
            BK_STREAM: begin
                if (out_free) begin
                    load      = 1'b1;
                    load_last = stream_last;
                    if (!stream_last) begin
                        rd_en   = 1'b1;
                        rd_addr = k_reg + 1'b1;
                        k_next  = k_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pat_mem[head.idx] <= head.data;
        end
        if (rd_en) begin
            rd_data_reg <= pat_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        k_reg   <= k_next;
        len_reg <= len_next;
        if (load) begin
            out_data_reg <= load_data;
            out_last_reg <= load_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_STREAM |-> ({1'b0, k_reg} < len_reg))
        else $error("pattern index ran past the pattern length");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_STREAM |-> !pop)
        else $error("queue popped during expansion");

endmodule
